// ===== rtl/apmb_pkg.sv =====
`default_nettype none

package apmb_pkg;

  // Fixed-point format and size of the rectangle inputs
  localparam int unsigned FracBits = 16;
  localparam int unsigned SizeBits = 16;

  localparam int unsigned CoefW = 32;
  // multiplier operand: signed point coordinate or zero-extended size
  localparam int unsigned OpW   = CoefW + 1;
  // products of a 32-bit coefficient and a 32-bit coordinate fit in 64 bits
  localparam int unsigned ProdW = 2 * CoefW;
  // two products plus a shift, with headroom
  localparam int unsigned SumW  = ProdW + 2;
  localparam int unsigned OutW  = 32;

  localparam int unsigned InFieldsW = 2 * CoefW + 2 * SizeBits;
  localparam int unsigned InTdataW  = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutTdataW = 6 * OutW;

  localparam int unsigned NumStages = 5;

  // register map, word index into the configuration space
  localparam int unsigned RegIdxW = 3;
  localparam int unsigned AddrW   = RegIdxW + 2;

  localparam logic [RegIdxW-1:0] RegCoefXx = 3'd0;
  localparam logic [RegIdxW-1:0] RegCoefXy = 3'd1;
  localparam logic [RegIdxW-1:0] RegShiftX = 3'd2;
  localparam logic [RegIdxW-1:0] RegCoefYx = 3'd3;
  localparam logic [RegIdxW-1:0] RegCoefYy = 3'd4;
  localparam logic [RegIdxW-1:0] RegShiftY = 3'd5;

  localparam logic signed [CoefW-1:0] CoefOne = CoefW'(1 << FracBits);
  localparam logic signed [SumW-1:0]  FracMask = SumW'((1 << FracBits) - 1);

  typedef struct packed {
    logic signed [CoefW-1:0] xx;
    logic signed [CoefW-1:0] xy;
    logic signed [CoefW-1:0] sx;
    logic signed [CoefW-1:0] yx;
    logic signed [CoefW-1:0] yy;
    logic signed [CoefW-1:0] sy;
  } apmb_coef_t;

  // load enables of the stages behind the input register
  typedef struct packed {
    logic prod;
    logic sum;
    logic span;
    logic res;
  } apmb_adv_t;

  function automatic logic [OutW-1:0] sat_s32(input logic signed [SumW-1:0] v);
    logic [OutW-1:0] r;
    if (v[SumW-1] && !(&v[SumW-1:OutW-1])) begin
      r = {1'b1, {(OutW-1){1'b0}}};
    end else if (!v[SumW-1] && (|v[SumW-1:OutW-1])) begin
      r = {1'b0, {(OutW-1){1'b1}}};
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

  function automatic logic [OutW-1:0] sat_u32(input logic signed [SumW-1:0] v);
    logic [OutW-1:0] r;
    if (v[SumW-1]) begin
      r = '0;
    end else if (|v[SumW-2:OutW]) begin
      r = '1;
    end else begin
      r = v[OutW-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/apmb_cfg.sv =====
`default_nettype none

module apmb_cfg
  import apmb_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [CoefW-1:0]  pwdata,
  output logic [CoefW-1:0]  prdata,
  output logic              pready,
  output apmb_coef_t        coef_o
);

  apmb_coef_t          coef_q, coef_d;
  logic [RegIdxW-1:0]  idx;
  logic                wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[AddrW-1:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_comb begin
    coef_d = coef_q;
    if (wr_en) begin
      case (idx)
        RegCoefXx: coef_d.xx = pwdata;
        RegCoefXy: coef_d.xy = pwdata;
        RegShiftX: coef_d.sx = pwdata;
        RegCoefYx: coef_d.yx = pwdata;
        RegCoefYy: coef_d.yy = pwdata;
        RegShiftY: coef_d.sy = pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      RegCoefXx: prdata = coef_q.xx;
      RegCoefXy: prdata = coef_q.xy;
      RegShiftX: prdata = coef_q.sx;
      RegCoefYx: prdata = coef_q.yx;
      RegCoefYy: prdata = coef_q.yy;
      RegShiftY: prdata = coef_q.sy;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.xx <= CoefOne;
      coef_q.xy <= '0;
      coef_q.sx <= '0;
      coef_q.yx <= '0;
      coef_q.yy <= CoefOne;
      coef_q.sy <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

`default_nettype wire

// ===== rtl/apmb_axis.sv =====
`default_nettype none

// One output axis: products, corner sums, min/max, then floor/ceil and saturation.
module apmb_axis
  import apmb_pkg::*;
(
  input  logic                    clk_i,
  input  apmb_adv_t               adv_i,
  input  logic                    mode_i,
  input  logic signed [OpW-1:0]   op_x_i,
  input  logic signed [OpW-1:0]   op_y_i,
  input  logic signed [CoefW-1:0] coef_a_i,
  input  logic signed [CoefW-1:0] coef_b_i,
  input  logic signed [CoefW-1:0] shift_i,
  output logic [OutW-1:0]         mapped_o,
  output logic [OutW-1:0]         left_o,
  output logic [OutW-1:0]         size_o
);

  logic signed [CoefW+OpW-1:0] prod_a, prod_b;
  logic signed [ProdW-1:0]     pa_q, pb_q;
  logic                        mode_p_q, mode_s_q, mode_m_q;
  logic signed [SumW-1:0]      t_ext, pa_ext, pb_ext;
  logic signed [SumW-1:0]      c1_d, c2_d, c3_d, c1_q, c2_q, c3_q;
  logic signed [SumW-1:0]      lo01, lo23, hi01, hi23, lo_d, hi_d, lo_q, hi_q;
  logic signed [SumW-1:0]      fl, ce;
  logic [OutW-1:0]             mapped_d, left_d, size_d, mapped_q, left_q, size_q;

  // stage: products
  assign prod_a = coef_a_i * op_x_i;
  assign prod_b = coef_b_i * op_y_i;

  always_ff @(posedge clk_i) begin
    if (adv_i.prod) begin
      pa_q     <= prod_a[ProdW-1:0];
      pb_q     <= prod_b[ProdW-1:0];
      mode_p_q <= mode_i;
    end
  end

  // stage: corner sums; in point mode the last slot carries the mapped value
  assign t_ext  = SumW'(shift_i);
  assign pa_ext = SumW'(pa_q);
  assign pb_ext = SumW'(pb_q);

  always_comb begin
    c1_d = pa_ext + t_ext;
    c2_d = pb_ext + t_ext;
    if (mode_p_q) begin
      c3_d = pa_ext + pb_ext + t_ext;
    end else begin
      c3_d = ((pa_ext + pb_ext) >>> FracBits) + t_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.sum) begin
      c1_q     <= c1_d;
      c2_q     <= c2_d;
      c3_q     <= c3_d;
      mode_s_q <= mode_p_q;
    end
  end

  // stage: extent over the four corners, the first corner being the shift alone
  always_comb begin
    lo01 = (c1_q < t_ext) ? c1_q : t_ext;
    hi01 = (c1_q > t_ext) ? c1_q : t_ext;
    lo23 = (c3_q < c2_q) ? c3_q : c2_q;
    hi23 = (c3_q > c2_q) ? c3_q : c2_q;
    if (mode_s_q) begin
      lo_d = (lo23 < lo01) ? lo23 : lo01;
      hi_d = (hi23 > hi01) ? hi23 : hi01;
    end else begin
      lo_d = c3_q;
      hi_d = c3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.span) begin
      lo_q     <= lo_d;
      hi_q     <= hi_d;
      mode_m_q <= mode_s_q;
    end
  end

  // stage: whole-pixel box and saturation
  always_comb begin
    fl = lo_q >>> FracBits;
    ce = (hi_q + FracMask) >>> FracBits;
    if (mode_m_q) begin
      mapped_d = '0;
      left_d   = sat_s32(fl);
      size_d   = sat_u32(ce - fl);
    end else begin
      mapped_d = sat_s32(lo_q);
      left_d   = '0;
      size_d   = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.res) begin
      mapped_q <= mapped_d;
      left_q   <= left_d;
      size_q   <= size_d;
    end
  end

  assign mapped_o = mapped_q;
  assign left_o   = left_q;
  assign size_o   = size_q;

endmodule

`default_nettype wire

// ===== rtl/affine_point_map_bbox_top.sv =====
// Channel  | Dir | Beat contents
// s_axis   | in  | tuser: mode; tdata: point_x, point_y, rect_width, rect_height
// m_axis   | out | tdata: mapped_x, mapped_y, box_left, box_top, box_width, box_height
// APB      | in  | six 32-bit matrix registers at byte address 4*i, zero wait states
//
// One beat is taken per cycle until an m_axis stall fills the pipe; each result passes
// through the input register, multiply, corner sums, min/max and result register stages.
// Each stage has its own valid bit, so bubbles close up while m_axis stalls and
// s_axis keeps taking beats until every stage is full.
// Reset is asynchronous and active low; it empties the pipe and loads the identity matrix.
`default_nettype none

module affine_point_map_bbox_top
  import apmb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // point_x [31:0], point_y [63:32], rect_width [79:64], rect_height [95:80]
  input  logic [InTdataW-1:0]  s_axis_tdata,
  // mode
  input  logic                 s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // mapped_x, mapped_y, box_left, box_top, box_width, box_height, 32 bits each
  output logic [OutTdataW-1:0] m_axis_tdata,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [AddrW-1:0]     paddr,
  input  logic [CoefW-1:0]     pwdata,
  output logic [CoefW-1:0]     prdata,
  output logic                 pready
);

  apmb_coef_t               coef;
  apmb_adv_t                adv;
  logic [NumStages-1:0]     vld_q, vld_d, en;
  logic                     mode_q;
  logic signed [CoefW-1:0]  x_q, y_q;
  logic [SizeBits-1:0]      w_q, h_q;
  logic signed [OpW-1:0]    op_x, op_y;
  logic [OutW-1:0]          mapped_x, mapped_y, box_left, box_top, box_width, box_height;

  apmb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coef_o  (coef)
  );

  // a stage loads when it is empty or the stage after it loads
  always_comb begin
    en[NumStages-1] = !vld_q[NumStages-1] | m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !vld_q[k] | en[k+1];
    end
    vld_d[0] = en[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NumStages; k++) begin
      vld_d[k] = en[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = vld_q[NumStages-1];

  assign adv.prod = en[1];
  assign adv.sum  = en[2];
  assign adv.span = en[3];
  assign adv.res  = en[4];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      mode_q <= s_axis_tuser;
      x_q    <= s_axis_tdata[CoefW-1:0];
      y_q    <= s_axis_tdata[2*CoefW-1:CoefW];
      w_q    <= s_axis_tdata[2*CoefW +: SizeBits];
      h_q    <= s_axis_tdata[2*CoefW+SizeBits +: SizeBits];
    end
  end

  // box mode multiplies by the rectangle size, point mode by the coordinates
  assign op_x = mode_q ? $signed({{(OpW-SizeBits){1'b0}}, w_q}) : OpW'(x_q);
  assign op_y = mode_q ? $signed({{(OpW-SizeBits){1'b0}}, h_q}) : OpW'(y_q);

  apmb_axis u_axis_x (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .mode_i   (mode_q),
    .op_x_i   (op_x),
    .op_y_i   (op_y),
    .coef_a_i (coef.xx),
    .coef_b_i (coef.xy),
    .shift_i  (coef.sx),
    .mapped_o (mapped_x),
    .left_o   (box_left),
    .size_o   (box_width)
  );

  apmb_axis u_axis_y (
    .clk_i    (clk_i),
    .adv_i    (adv),
    .mode_i   (mode_q),
    .op_x_i   (op_x),
    .op_y_i   (op_y),
    .coef_a_i (coef.yx),
    .coef_b_i (coef.yy),
    .shift_i  (coef.sy),
    .mapped_o (mapped_y),
    .left_o   (box_top),
    .size_o   (box_height)
  );

  assign m_axis_tdata = {box_height, box_width, box_top, box_left, mapped_y, mapped_x};

endmodule

`default_nettype wire

// ===== rtl/apmb_checker.sv =====
`default_nettype none

module apmb_checker
  import apmb_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [OutTdataW-1:0] m_axis_tdata
);

  logic [2:0] inflight_q, inflight_d;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid & s_axis_tready;
  assign out_beat = m_axis_tvalid & m_axis_tready;

  always_comb begin
    inflight_d = inflight_q;
    if (in_beat && !out_beat) begin
      inflight_d = inflight_q + 3'd1;
    end else if (!in_beat && out_beat) begin
      inflight_d = inflight_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with an empty output register");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> inflight_q != 3'd0)
    else $error("result beat without a pending input beat");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q <= 3'(NumStages))
    else $error("more beats in flight than pipeline stages");

  a_mode_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[2*OutW-1:0] != '0) |-> m_axis_tdata[6*OutW-1:2*OutW] == '0)
    else $error("point result carries box fields");

endmodule

bind affine_point_map_bbox_top apmb_checker u_apmb_checker (.*);

`default_nettype wire
